// ===== hw/rtl/rv32if_pkg.sv =====
package rv32if_pkg;

    typedef enum logic [2:0] {
        KIND_NONE = 3'd0,
        KIND_INT  = 3'd1,
        KIND_ZERO = 3'd2,
        KIND_FLT  = 3'd3,
        KIND_IMM  = 3'd4
    } t_kind;

    typedef enum logic [3:0] {
        FMT_I, FMT_R, FMT_S, FMT_B, FMT_U, FMT_AUIPC, FMT_J, FMT_CSR,
        FMT_FLOAD, FMT_FSTORE, FMT_FR, FMT_FR2R, FMT_R2FR
    } t_fmt;

    typedef logic [6:0] t_id;

    localparam t_id ID_INVALID = 7'd0;
    localparam t_id ID_LB = 7'd1, ID_LH = 7'd2, ID_LW = 7'd3, ID_LBU = 7'd4, ID_LHU = 7'd5;
    localparam t_id ID_SB = 7'd6, ID_SH = 7'd7, ID_SW = 7'd8;
    localparam t_id ID_ADDI = 7'd9, ID_SLLI = 7'd10, ID_SLTI = 7'd11, ID_SLTIU = 7'd12;
    localparam t_id ID_XORI = 7'd13, ID_SRLI = 7'd14, ID_SRAI = 7'd15, ID_ORI = 7'd16;
    localparam t_id ID_ANDI = 7'd17, ID_AUIPC = 7'd18, ID_LUI = 7'd19;
    localparam t_id ID_ADD = 7'd20, ID_SUB = 7'd21, ID_SLL = 7'd22, ID_SLT = 7'd23;
    localparam t_id ID_SLTU = 7'd24, ID_XOR = 7'd25, ID_SRL = 7'd26, ID_SRA = 7'd27;
    localparam t_id ID_OR = 7'd28, ID_AND = 7'd29;
    localparam t_id ID_BEQ = 7'd30, ID_BNE = 7'd31, ID_BLT = 7'd32, ID_BGE = 7'd33;
    localparam t_id ID_BLTU = 7'd34, ID_BGEU = 7'd35;
    localparam t_id ID_JALR = 7'd36, ID_RET = 7'd37, ID_JAL = 7'd38, ID_EBREAK = 7'd39;
    localparam t_id ID_CSRRW = 7'd40, ID_CSRRS = 7'd41, ID_CSRRC = 7'd42;
    localparam t_id ID_CSRRWI = 7'd43, ID_CSRRSI = 7'd44, ID_CSRRCI = 7'd45;
    localparam t_id ID_FLW = 7'd46, ID_FSW = 7'd47;
    localparam t_id ID_FMADD = 7'd48, ID_FMSUB = 7'd49, ID_FNMSUB = 7'd50, ID_FNMADD = 7'd51;
    localparam t_id ID_FADD = 7'd52, ID_FSUB = 7'd53, ID_FMUL = 7'd54, ID_FDIV = 7'd55;
    localparam t_id ID_FSQRT = 7'd56, ID_FSGNJ = 7'd57, ID_FSGNJN = 7'd58, ID_FSGNJX = 7'd59;
    localparam t_id ID_FMIN = 7'd60, ID_FMAX = 7'd61, ID_FCVT_W_S = 7'd62;
    localparam t_id ID_FCVT_WU_S = 7'd63, ID_FMV_X_W = 7'd64, ID_FCLASS = 7'd65;
    localparam t_id ID_FLE = 7'd66, ID_FLT = 7'd67, ID_FEQ = 7'd68;
    localparam t_id ID_FCVT_S_W = 7'd69, ID_FCVT_S_WU = 7'd70, ID_FMV_W_X = 7'd71;
    localparam t_id ID_FCVT_BF16_S = 7'd72, ID_FCVT_S_BF16 = 7'd73;
    localparam t_id ID_FCVT_E4M3_S = 7'd74, ID_FCVT_S_E4M3 = 7'd75;
    localparam t_id ID_FCVT_E5M2_S = 7'd76, ID_FCVT_S_E5M2 = 7'd77;
    localparam t_id ID_FCVT_E2M1_S = 7'd78, ID_FCVT_S_E2M1 = 7'd79;

    localparam logic [4:0] OPC_LOAD = 5'd0, OPC_LOAD_FP = 5'd1, OPC_OP_IMM = 5'd4;
    localparam logic [4:0] OPC_AUIPC = 5'd5, OPC_STORE = 5'd8, OPC_STORE_FP = 5'd9;
    localparam logic [4:0] OPC_OP = 5'd12, OPC_LUI = 5'd13, OPC_MADD = 5'd16;
    localparam logic [4:0] OPC_MSUB = 5'd17, OPC_NMSUB = 5'd18, OPC_NMADD = 5'd19;
    localparam logic [4:0] OPC_OP_FP = 5'd20, OPC_BRANCH = 5'd24, OPC_JALR = 5'd25;
    localparam logic [4:0] OPC_JAL = 5'd27, OPC_SYSTEM = 5'd28;

    localparam logic [6:0] F7_ALT = 7'h20, F7_CVT_BF16 = 7'h22;
    localparam logic [6:0] F7_CVT_FP8 = 7'h24, F7_CVT_FP4 = 7'h26;

    localparam logic [4:0] F5_FADD = 5'd0, F5_FSUB = 5'd1, F5_FMUL = 5'd2, F5_FDIV = 5'd3;
    localparam logic [4:0] F5_FSGNJ = 5'd4, F5_FMINMAX = 5'd5, F5_FSQRT = 5'd11;
    localparam logic [4:0] F5_FCMP = 5'd20, F5_FCVT_W = 5'd24, F5_FCVT_S = 5'd26;
    localparam logic [4:0] F5_FMV_X = 5'd28, F5_FMV_W = 5'd30;

    localparam logic [31:0] LINK_STEP = 32'd4;

    typedef struct packed {
        t_kind       kind;
        logic [4:0]  idx;
        logic [31:0] imm;
    } t_slot;

    typedef struct packed {
        t_id  id;
        t_fmt fmt;
    } t_dec;

    typedef struct packed {
        t_id   id;
        t_slot src1;
        t_slot src2;
        t_slot dest;
    } t_result;

    function automatic t_slot slot_none();
        t_slot s;
        s.kind = KIND_NONE;
        s.idx  = 5'd0;
        s.imm  = 32'd0;
        return s;
    endfunction

    function automatic t_slot slot_int(input logic [4:0] r, input logic keep_x0);
        t_slot s;
        s.kind = (!keep_x0 && r == 5'd0) ? KIND_ZERO : KIND_INT;
        s.idx  = r;
        s.imm  = 32'd0;
        return s;
    endfunction

    function automatic t_slot slot_flt(input logic [4:0] r);
        t_slot s;
        s.kind = KIND_FLT;
        s.idx  = r;
        s.imm  = 32'd0;
        return s;
    endfunction

    function automatic t_slot slot_imm(input logic [31:0] v);
        t_slot s;
        s.kind = KIND_IMM;
        s.idx  = 5'd0;
        s.imm  = v;
        return s;
    endfunction

endpackage

// ===== hw/rtl/rv32if_id_dec.sv =====
module rv32if_id_dec
    import rv32if_pkg::*;
(
    input  logic [31:0] i_instr,
    output t_dec        o_dec
);

    logic [4:0] opc;
    logic [2:0] f3;
    logic [6:0] f7;
    logic [4:0] f5;
    logic [4:0] r2;

    assign opc = i_instr[6:2];
    assign f3  = i_instr[14:12];
    assign f7  = i_instr[31:25];
    assign f5  = i_instr[31:27];
    assign r2  = i_instr[24:20];

    always_comb begin
        o_dec.id  = ID_INVALID;
        o_dec.fmt = FMT_I;
        case (opc)
            OPC_LOAD: begin
                o_dec.fmt = FMT_I;
                case (f3)
                    3'd0: o_dec.id = ID_LB;
                    3'd1: o_dec.id = ID_LH;
                    3'd2: o_dec.id = ID_LW;
                    3'd4: o_dec.id = ID_LBU;
                    3'd5: o_dec.id = ID_LHU;
                    default: o_dec.id = ID_INVALID;
                endcase
            end
            OPC_STORE: begin
                o_dec.fmt = FMT_S;
                case (f3)
                    3'd0: o_dec.id = ID_SB;
                    3'd1: o_dec.id = ID_SH;
                    3'd2: o_dec.id = ID_SW;
                    default: o_dec.id = ID_INVALID;
                endcase
            end
            OPC_OP_IMM: begin
                o_dec.fmt = FMT_I;
                case (f3)
                    3'd0: o_dec.id = ID_ADDI;
                    3'd1: o_dec.id = ID_SLLI;
                    3'd2: o_dec.id = ID_SLTI;
                    3'd3: o_dec.id = ID_SLTIU;
                    3'd4: o_dec.id = ID_XORI;
                    3'd5: o_dec.id = (f7 == F7_ALT) ? ID_SRAI : ID_SRLI;
                    3'd6: o_dec.id = ID_ORI;
                    default: o_dec.id = ID_ANDI;
                endcase
            end
            OPC_AUIPC: begin
                o_dec.fmt = FMT_AUIPC;
                o_dec.id  = ID_AUIPC;
            end
            OPC_OP: begin
                o_dec.fmt = FMT_R;
                case (f3)
                    3'd0: o_dec.id = (f7 == F7_ALT) ? ID_SUB : ID_ADD;
                    3'd1: o_dec.id = ID_SLL;
                    3'd2: o_dec.id = ID_SLT;
                    3'd3: o_dec.id = ID_SLTU;
                    3'd4: o_dec.id = ID_XOR;
                    3'd5: o_dec.id = (f7 == F7_ALT) ? ID_SRA : ID_SRL;
                    3'd6: o_dec.id = ID_OR;
                    default: o_dec.id = ID_AND;
                endcase
            end
            OPC_LUI: begin
                o_dec.fmt = FMT_U;
                o_dec.id  = ID_LUI;
            end
            OPC_BRANCH: begin
                o_dec.fmt = FMT_B;
                case (f3)
                    3'd0: o_dec.id = ID_BEQ;
                    3'd1: o_dec.id = ID_BNE;
                    3'd4: o_dec.id = ID_BLT;
                    3'd5: o_dec.id = ID_BGE;
                    3'd6: o_dec.id = ID_BLTU;
                    3'd7: o_dec.id = ID_BGEU;
                    default: o_dec.id = ID_INVALID;
                endcase
            end
            OPC_JALR: begin
                o_dec.fmt = FMT_I;
                if (i_instr[11:7] == 5'd0 && i_instr[31:20] == 12'd0
                        && i_instr[19:15] == 5'd1) begin
                    o_dec.id = ID_RET;
                end else begin
                    o_dec.id = ID_JALR;
                end
            end
            OPC_JAL: begin
                o_dec.fmt = FMT_J;
                o_dec.id  = ID_JAL;
            end
            OPC_SYSTEM: begin
                o_dec.fmt = FMT_CSR;
                case (f3)
                    3'd0: o_dec.id = ID_EBREAK;
                    3'd1: o_dec.id = ID_CSRRW;
                    3'd2: o_dec.id = ID_CSRRS;
                    3'd3: o_dec.id = ID_CSRRC;
                    3'd5: o_dec.id = ID_CSRRWI;
                    3'd6: o_dec.id = ID_CSRRSI;
                    3'd7: o_dec.id = ID_CSRRCI;
                    default: o_dec.id = ID_INVALID;
                endcase
            end
            OPC_LOAD_FP: begin
                o_dec.fmt = FMT_FLOAD;
                o_dec.id  = (f3 == 3'd2) ? ID_FLW : ID_INVALID;
            end
            OPC_STORE_FP: begin
                o_dec.fmt = FMT_FSTORE;
                o_dec.id  = (f3 == 3'd2) ? ID_FSW : ID_INVALID;
            end
            OPC_MADD: begin
                o_dec.fmt = FMT_FR;
                o_dec.id  = ID_FMADD;
            end
            OPC_MSUB: begin
                o_dec.fmt = FMT_FR;
                o_dec.id  = ID_FMSUB;
            end
            OPC_NMSUB: begin
                o_dec.fmt = FMT_FR;
                o_dec.id  = ID_FNMSUB;
            end
            OPC_NMADD: begin
                o_dec.fmt = FMT_FR;
                o_dec.id  = ID_FNMADD;
            end
            OPC_OP_FP: begin
                o_dec.fmt = FMT_FR;
                if (f7 == F7_CVT_BF16) begin
                    case (r2)
                        5'd0: o_dec.id = ID_FCVT_S_BF16;
                        5'd1: o_dec.id = ID_FCVT_BF16_S;
                        default: o_dec.id = ID_INVALID;
                    endcase
                end else if (f7 == F7_CVT_FP8) begin
                    case (r2)
                        5'd0: o_dec.id = ID_FCVT_S_E4M3;
                        5'd1: o_dec.id = ID_FCVT_E4M3_S;
                        5'd2: o_dec.id = ID_FCVT_S_E5M2;
                        5'd3: o_dec.id = ID_FCVT_E5M2_S;
                        default: o_dec.id = ID_INVALID;
                    endcase
                end else if (f7 == F7_CVT_FP4) begin
                    case (r2)
                        5'd0: o_dec.id = ID_FCVT_S_E2M1;
                        5'd1: o_dec.id = ID_FCVT_E2M1_S;
                        default: o_dec.id = ID_INVALID;
                    endcase
                end else begin
                    case (f5)
                        F5_FADD:  o_dec.id = ID_FADD;
                        F5_FSUB:  o_dec.id = ID_FSUB;
                        F5_FMUL:  o_dec.id = ID_FMUL;
                        F5_FDIV:  o_dec.id = ID_FDIV;
                        F5_FSQRT: o_dec.id = ID_FSQRT;
                        F5_FSGNJ: begin
                            case (f3)
                                3'd0: o_dec.id = ID_FSGNJ;
                                3'd1: o_dec.id = ID_FSGNJN;
                                3'd2: o_dec.id = ID_FSGNJX;
                                default: o_dec.id = ID_INVALID;
                            endcase
                        end
                        F5_FMINMAX: begin
                            case (f3)
                                3'd0: o_dec.id = ID_FMIN;
                                3'd1: o_dec.id = ID_FMAX;
                                default: o_dec.id = ID_INVALID;
                            endcase
                        end
                        F5_FCVT_W: begin
                            o_dec.fmt = FMT_FR2R;
                            case (r2)
                                5'd0: o_dec.id = ID_FCVT_W_S;
                                5'd1: o_dec.id = ID_FCVT_WU_S;
                                default: o_dec.id = ID_INVALID;
                            endcase
                        end
                        F5_FMV_X: begin
                            o_dec.fmt = FMT_FR2R;
                            case (f3)
                                3'd0: o_dec.id = ID_FMV_X_W;
                                3'd1: o_dec.id = ID_FCLASS;
                                default: o_dec.id = ID_INVALID;
                            endcase
                        end
                        F5_FCMP: begin
                            o_dec.fmt = FMT_FR2R;
                            case (f3)
                                3'd0: o_dec.id = ID_FLE;
                                3'd1: o_dec.id = ID_FLT;
                                3'd2: o_dec.id = ID_FEQ;
                                default: o_dec.id = ID_INVALID;
                            endcase
                        end
                        F5_FCVT_S: begin
                            o_dec.fmt = FMT_R2FR;
                            case (r2)
                                5'd0: o_dec.id = ID_FCVT_S_W;
                                5'd1: o_dec.id = ID_FCVT_S_WU;
                                default: o_dec.id = ID_INVALID;
                            endcase
                        end
                        F5_FMV_W: begin
                            o_dec.fmt = FMT_R2FR;
                            o_dec.id  = ID_FMV_W_X;
                        end
                        default: o_dec.id = ID_INVALID;
                    endcase
                end
            end
            default: begin
                o_dec.fmt = FMT_I;
                o_dec.id  = ID_INVALID;
            end
        endcase
    end

endmodule

// ===== hw/rtl/rv32if_opnd.sv =====
module rv32if_opnd
    import rv32if_pkg::*;
(
    input  logic [31:0] i_instr,
    input  logic [31:0] i_pc,
    input  t_dec        i_dec,
    output t_result     o_result
);

    logic [4:0]  rd;
    logic [4:0]  rs1;
    logic [4:0]  rs2;
    logic [31:0] imm_i;
    logic [31:0] imm_s;
    logic [31:0] imm_u;
    logic [31:0] off_b;
    logic [31:0] off_j;
    logic [31:0] csr_num;
    logic [31:0] pc_addend;
    logic [31:0] pc_target;
    logic [31:0] pc_link;

    assign rd      = i_instr[11:7];
    assign rs1     = i_instr[19:15];
    assign rs2     = i_instr[24:20];
    assign imm_i   = {{20{i_instr[31]}}, i_instr[31:20]};
    assign imm_s   = {{20{i_instr[31]}}, i_instr[31:25], i_instr[11:7]};
    assign imm_u   = {i_instr[31:12], 12'd0};
    assign off_b   = {{19{i_instr[31]}}, i_instr[31], i_instr[7], i_instr[30:25],
                      i_instr[11:8], 1'b0};
    assign off_j   = {{11{i_instr[31]}}, i_instr[31], i_instr[19:12], i_instr[20],
                      i_instr[30:21], 1'b0};
    assign csr_num = {20'd0, i_instr[31:20]};

    always_comb begin
        case (i_dec.fmt)
            FMT_B:   pc_addend = off_b;
            FMT_J:   pc_addend = off_j;
            default: pc_addend = imm_u;
        endcase
    end

    assign pc_target = i_pc + pc_addend;
    assign pc_link   = i_pc + LINK_STEP;

    always_comb begin
        o_result.id   = i_dec.id;
        o_result.src1 = slot_none();
        o_result.src2 = slot_none();
        o_result.dest = slot_none();
        if (i_dec.id != ID_INVALID) begin
            case (i_dec.fmt)
                FMT_I: begin
                    o_result.src1 = slot_int(rs1, 1'b1);
                    o_result.src2 = slot_imm(imm_i);
                    o_result.dest = slot_int(rd, 1'b0);
                end
                FMT_R: begin
                    o_result.src1 = slot_int(rs1, 1'b1);
                    o_result.src2 = slot_int(rs2, 1'b1);
                    o_result.dest = slot_int(rd, 1'b0);
                end
                FMT_S: begin
                    o_result.src1 = slot_int(rs1, 1'b1);
                    o_result.src2 = slot_imm(imm_s);
                    o_result.dest = slot_int(rs2, 1'b1);
                end
                FMT_B: begin
                    o_result.src1 = slot_int(rs1, 1'b1);
                    o_result.src2 = slot_int(rs2, 1'b1);
                    o_result.dest = slot_imm(pc_target);
                end
                FMT_U: begin
                    o_result.src1 = slot_imm(imm_u);
                    o_result.dest = slot_int(rd, 1'b0);
                end
                FMT_AUIPC: begin
                    o_result.src1 = slot_imm(pc_target);
                    o_result.dest = slot_int(rd, 1'b0);
                end
                FMT_J: begin
                    o_result.src1 = slot_imm(pc_target);
                    o_result.src2 = slot_imm(pc_link);
                    o_result.dest = slot_int(rd, 1'b0);
                end
                FMT_CSR: begin
                    o_result.src1 = slot_int(rs1, 1'b1);
                    o_result.src2 = slot_imm(csr_num);
                    o_result.dest = slot_int(rd, 1'b0);
                end
                FMT_FLOAD: begin
                    o_result.src1 = slot_int(rs1, 1'b0);
                    o_result.src2 = slot_imm(imm_i);
                    o_result.dest = slot_flt(rd);
                end
                FMT_FSTORE: begin
                    o_result.src1 = slot_int(rs1, 1'b1);
                    o_result.src2 = slot_imm(imm_s);
                    o_result.dest = slot_flt(rs2);
                end
                FMT_FR2R: begin
                    o_result.src1 = slot_flt(rs1);
                    o_result.src2 = slot_flt(rs2);
                    o_result.dest = slot_int(rd, 1'b0);
                end
                FMT_R2FR: begin
                    o_result.src1 = slot_int(rs1, 1'b1);
                    o_result.src2 = slot_int(rs2, 1'b1);
                    o_result.dest = slot_flt(rd);
                end
                default: begin
                    o_result.src1 = slot_flt(rs1);
                    o_result.src2 = slot_flt(rs2);
                    o_result.dest = slot_flt(rd);
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/rv32if_instruction_decoder.sv =====
// Structure: an input register holds the accepted item and a result register holds its decode.
// Throughput: one item per cycle; the decode is a single pass of logic between the two
// registers. While a finished result waits, the input register still takes one more item,
// then the input side stalls until the result is accepted.
// Reset: synchronous active-low i_rst_n clears both valid flags; payload is not reset.
module rv32if_instruction_decoder
    import rv32if_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [63:0]  s_axis_tdata,  // instr_word[31:0], pc_value[63:32]
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // instr_id[6:0], src1_kind[9:7], src1_reg[14:10], src1_imm[46:15],
    // src2_kind[49:47], src2_reg[54:50], src2_imm[86:55], dest_kind[89:87],
    // dest_reg[94:90], dest_imm[126:95], zero pad[127]
    output logic [127:0] m_axis_tdata
);

    logic        r_in_valid;
    logic [31:0] r_instr;
    logic [31:0] r_pc;
    logic        r_out_valid;
    t_result     r_result;
    t_result     n_result;
    t_dec        dec;
    logic        advance;

    rv32if_id_dec u_id_dec (
        .i_instr (r_instr),
        .o_dec   (dec)
    );

    rv32if_opnd u_opnd (
        .i_instr  (r_instr),
        .i_pc     (r_pc),
        .i_dec    (dec),
        .o_result (n_result)
    );

    assign advance       = !r_out_valid || m_axis_tready;
    assign s_axis_tready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (advance) begin
                r_out_valid <= r_in_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_instr <= s_axis_tdata[31:0];
            r_pc    <= s_axis_tdata[63:32];
        end
        if (advance && r_in_valid) begin
            r_result <= n_result;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {1'b0,
                            r_result.dest.imm, r_result.dest.idx, r_result.dest.kind,
                            r_result.src2.imm, r_result.src2.idx, r_result.src2.kind,
                            r_result.src1.imm, r_result.src1.idx, r_result.src1.kind,
                            r_result.id};

endmodule
